FILE: rtl/core/dedupq_pkg.sv
package dedupq_pkg;

  // Field widths fixed by the request and result formats
  localparam int unsigned ID_W     = 10;
  localparam int unsigned HANDLE_W = 32;
  localparam int unsigned OCC_W    = 11;

  // Defaults for the top-level parameters
  localparam int unsigned DEPTH_DEF       = 1024;
  localparam int unsigned HANDLE_BITS_DEF = 32;

  typedef enum logic [0:0] {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_e;

  typedef struct packed {
    op_e                 op;
    logic [ID_W-1:0]     event_id;
    logic [HANDLE_W-1:0] handle;
  } req_t;

  typedef struct packed {
    logic                out_valid;
    logic [ID_W-1:0]     out_id;
    logic [HANDLE_W-1:0] out_handle;
    logic                added;
    logic                empty_error;
    logic [OCC_W-1:0]    occupancy;
  } res_t;

endpackage

FILE: rtl/core/dedup_event_queue.sv
// Deduplicating event queue: enqueue or dequeue, one request per cycle while busy_o
// is low. An accepted request is held in the stage 1 request register; its result
// strobe (done_o) comes from the result register after stage 2. Throughput: one
// request every cycle while busy_o is low. Reset: pointers and count go to zero at
// once; the pending map is then swept clear one entry a cycle with busy_o high.
// Results are strobed for a single cycle; the receiver cannot stall them.
module dedup_event_queue #(
  parameter int unsigned DEPTH       = dedupq_pkg::DEPTH_DEF,
  parameter int unsigned HANDLE_BITS = dedupq_pkg::HANDLE_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  dedupq_pkg::req_t  req_i,
  output logic              busy_o,
  output logic              done_o,
  output dedupq_pkg::res_t  res_o
);

  localparam int unsigned IW = $clog2(DEPTH);       // ring / map index width
  localparam int unsigned CW = $clog2(DEPTH + 1);   // count width, holds DEPTH
  localparam int unsigned RW = dedupq_pkg::ID_W + HANDLE_BITS;  // ring entry

  // ---------------------------------------------------------------------------
  // Storage
  //   pend_ram : one bit per id, set while the id sits in the queue
  //   ring_ram : order ring; each entry holds the id and its handle. An id can be
  //              pending only once, so the handle stored with it in the ring is
  //              the one a handle-by-id table would return at pop time.
  // ---------------------------------------------------------------------------
  logic          pw_en;
  logic [IW-1:0] pw_addr;
  logic          pw_data;
  logic [IW-1:0] pr_addr;
  logic          pr_data;

  logic          rw_en;
  logic [IW-1:0] rw_addr;
  logic [RW-1:0] rw_data;
  logic [IW-1:0] rr_addr;
  logic [RW-1:0] rr_data;

  dedupq_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_pend_ram (
    .clk_i   (clk_i),
    .we_i    (pw_en),
    .waddr_i (pw_addr),
    .wdata_i (pw_data),
    .raddr_i (pr_addr),
    .rdata_o (pr_data)
  );

  dedupq_ram #(
    .WIDTH (RW),
    .DEPTH (DEPTH)
  ) u_ring_ram (
    .clk_i   (clk_i),
    .we_i    (rw_en),
    .waddr_i (rw_addr),
    .wdata_i (rw_data),
    .raddr_i (rr_addr),
    .rdata_o (rr_data)
  );

  // ---------------------------------------------------------------------------
  // Reset sweep of the pending map
  // ---------------------------------------------------------------------------
  logic          clearing_q;
  logic [IW-1:0] clr_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_idx_q  <= '0;
    end else if (clearing_q) begin
      clr_idx_q <= clr_idx_q + 1'b1;
      if (clr_idx_q == IW'(DEPTH - 1)) begin
        clearing_q <= 1'b0;
      end
    end
  end

  assign busy_o = clearing_q;

  // ---------------------------------------------------------------------------
  // Stage 1: request register. The pending bit of the incoming id is read
  // in the accept cycle so it is ready alongside the registered request.
  // ---------------------------------------------------------------------------
  logic             accept;
  logic             s2_valid_q;
  dedupq_pkg::req_t s2_req_q;

  assign accept  = start_i && !busy_o;
  assign pr_addr = IW'(req_i.event_id);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s2_req_q <= req_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Queue state
  // ---------------------------------------------------------------------------
  logic [IW-1:0] head_q, head_d;
  logic [IW-1:0] tail_q, tail_d;
  logic [CW-1:0] count_q, count_d;

  // Bypass registers: the write made in the same cycle as a RAM read is not
  // seen by that read (read-first), so it is held here for the next cycle.
  logic          pfw_en_q;
  logic [IW-1:0] pfw_addr_q;
  logic          pfw_data_q;
  logic          rfw_hit_q;
  logic [RW-1:0] rfw_data_q;

  // Result register
  logic             done_q;
  dedupq_pkg::res_t res_q;

  // ---------------------------------------------------------------------------
  // Stage 2: decide, update pointers and maps, form the result
  // ---------------------------------------------------------------------------
  logic                          s2_enq;
  logic                          s2_deq;
  logic [IW-1:0]                 s2_idx;
  logic                          id_in_range;
  logic                          pend_bit;
  logic [RW-1:0]                 head_entry;
  logic [dedupq_pkg::ID_W-1:0]   head_id;
  logic [HANDLE_BITS-1:0]        head_handle;
  logic                          do_add;
  logic                          do_pop;
  logic                          done_d;
  dedupq_pkg::res_t              res_d;

  assign s2_enq      = s2_valid_q && (s2_req_q.op == dedupq_pkg::OP_ENQ);
  assign s2_deq      = s2_valid_q && (s2_req_q.op == dedupq_pkg::OP_DEQ);
  assign s2_idx      = IW'(s2_req_q.event_id);
  assign id_in_range = 32'(s2_req_q.event_id) < 32'(DEPTH);

  assign pend_bit   = (pfw_en_q && (pfw_addr_q == s2_idx)) ? pfw_data_q : pr_data;
  assign head_entry = rfw_hit_q ? rfw_data_q : rr_data;
  assign head_id    = head_entry[RW-1 -: dedupq_pkg::ID_W];
  assign head_handle = head_entry[HANDLE_BITS-1:0];

  assign do_add = s2_enq && id_in_range && !pend_bit && (count_q < CW'(DEPTH));
  assign do_pop = s2_deq && (count_q != '0);

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (do_add) begin
      tail_d  = (tail_q == IW'(DEPTH - 1)) ? '0 : tail_q + 1'b1;
      count_d = count_q + 1'b1;
    end
    if (do_pop) begin
      head_d  = (head_q == IW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
      count_d = count_q - 1'b1;
    end
  end

  // Ring: append at the tail; keep the next head entry prefetched
  assign rw_en   = do_add;
  assign rw_addr = tail_q;
  assign rw_data = {s2_req_q.event_id, HANDLE_BITS'(s2_req_q.handle)};
  assign rr_addr = head_d;

  // Pending map: sweep, set on append, clear on pop
  always_comb begin
    pw_en   = 1'b0;
    pw_addr = s2_idx;
    pw_data = 1'b0;
    if (clearing_q) begin
      pw_en   = 1'b1;
      pw_addr = clr_idx_q;
    end else if (do_add) begin
      pw_en   = 1'b1;
      pw_data = 1'b1;
    end else if (do_pop) begin
      pw_en   = 1'b1;
      pw_addr = IW'(head_id);
    end
  end

  always_comb begin
    done_d            = s2_valid_q;
    res_d             = '0;
    res_d.occupancy   = dedupq_pkg::OCC_W'(count_d);
    res_d.added       = do_add;
    res_d.empty_error = s2_deq && !do_pop;
    if (do_pop) begin
      res_d.out_valid  = 1'b1;
      res_d.out_id     = head_id;
      res_d.out_handle = dedupq_pkg::HANDLE_W'(head_handle);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      tail_q    <= '0;
      count_q   <= '0;
      pfw_en_q  <= 1'b0;
      rfw_hit_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      head_q    <= head_d;
      tail_q    <= tail_d;
      count_q   <= count_d;
      pfw_en_q  <= pw_en;
      rfw_hit_q <= rw_en && (rw_addr == rr_addr);
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pfw_addr_q <= pw_addr;
    pfw_data_q <= pw_data;
    rfw_data_q <= rw_data;
    res_q      <= res_d;
  end

  // ---------------------------------------------------------------------------
  // Result outputs
  // ---------------------------------------------------------------------------
  assign done_o = done_q;
  assign res_o  = res_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("pending count above depth");

  a_no_work_in_sweep : assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_q |-> !s2_valid_q && !done_q)
    else $error("request in flight during pending map sweep");

  a_one_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q |=> done_q)
    else $error("request lost between stage 2 and result");

  a_result_kind : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !(res_q.out_valid && res_q.empty_error) &&
               !(res_q.out_valid && res_q.added))
    else $error("inconsistent result flags");

endmodule

FILE: rtl/core/dedupq_ram.sv
module dedupq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read-first: a read at the address being written returns the old word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
